// ===== sv/skewed_two_level_btb_macros.svh =====
// Assertion macros for the branch target buffer checker
`ifndef SKEWED_TWO_LEVEL_BTB_MACROS_SVH
`define SKEWED_TWO_LEVEL_BTB_MACROS_SVH
`define BTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BTB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/stlb_pkg.sv =====
// Shared types and constants for the two-level branch target buffer
`timescale 1ns / 1ps
`default_nettype none
package stlb_pkg;
  localparam int ADDR_W = 48;
  localparam int L2_TGT_OUT_W = 32;
  localparam int WAY_OUT_W = 2;
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL = 1'b1;
  localparam logic [1:0] LVL_L1 = 2'd0;
  localparam logic [1:0] LVL_L2 = 2'd1;
  localparam logic [1:0] LVL_BOTH = 2'd2;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch input word, start memory read
    logic clear;    // write one clearing row
    logic resolve;  // compare read data, write back, load output
  } stlb_cmd_t;

  typedef struct packed {
    logic clear_done;  // last row of the clearing pass
  } stlb_status_t;
endpackage
`default_nettype wire

// ===== sv/stlb_ctrl.sv =====
// Controller sequencing clearing pass, memory read and resolve steps
`timescale 1ns / 1ps
`default_nettype none
module stlb_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   out_busy,
  input  stlb_pkg::stlb_status_t status,
  output stlb_pkg::stlb_cmd_t   cmd
);
  import stlb_pkg::*;
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !out_busy;
        if (in_valid && !out_busy) begin
          cmd.capture = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.resolve = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// ===== sv/stlb_dp.sv =====
// Datapath: L1 and L2 tables, hit detection, replacement and result register
`timescale 1ns / 1ps
`default_nettype none
module stlb_dp #(
  parameter int L1_SET_BITS = 6,
  parameter int L1_WAYS = 4,
  parameter int L2_SET_BITS = 10,
  parameter int L2_WAYS = 4,
  parameter int L2_TAG_BITS = 12,
  parameter int L2_TARGET_BITS = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  stlb_pkg::stlb_cmd_t        cmd,
  output stlb_pkg::stlb_status_t     status,
  input  wire                        in_opcode,
  input  wire [stlb_pkg::ADDR_W-1:0] in_branch,
  input  wire [stlb_pkg::ADDR_W-1:0] in_target,
  input  wire [1:0]                  in_level,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [87:0]                out_data
);
  import stlb_pkg::*;
  localparam int L1_SETS = 1 << L1_SET_BITS;
  localparam int L2_SETS = 1 << L2_SET_BITS;
  localparam int L1_TAG_W = ADDR_W - 2 - L1_SET_BITS;
  localparam int L1_WB = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int L2_WB = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int AGE_W = L1_WB;
  localparam int L1_ROW_W = L1_WAYS * (1 + L1_TAG_W + ADDR_W + AGE_W);
  localparam int L2_ROW_W = 1 + L2_TAG_BITS + L2_TARGET_BITS;
  localparam int CLR_W = (L2_SET_BITS > L1_SET_BITS) ? L2_SET_BITS : L1_SET_BITS;

  typedef struct packed {
    logic [L1_WAYS-1:0]                v;
    logic [L1_WAYS-1:0][L1_TAG_W-1:0]  tag;
    logic [L1_WAYS-1:0][ADDR_W-1:0]    tgt;
    logic [L1_WAYS-1:0][AGE_W-1:0]     age;
  } l1_row_t;
  typedef struct packed {
    logic                      v;
    logic [L2_TAG_BITS-1:0]    tag;
    logic [L2_TARGET_BITS-1:0] tgt;
  } l2_ent_t;

  // L1 row memory: one row per set holds all ways
  logic [L1_ROW_W-1:0] l1_mem [L1_SETS];
  l1_row_t l1_rd;
  logic [L1_SET_BITS-1:0] l1_waddr;
  l1_row_t l1_wdata;
  logic l1_we;

  // L2: one memory per way (skewed index per way)
  logic [L2_ROW_W-1:0] l2_rd [L2_WAYS];
  logic [L2_WAYS-1:0][L2_SET_BITS-1:0] l2_idx, l2_idx_q;
  logic [L2_WAYS-1:0] l2_we;
  l2_ent_t l2_wdata;
  logic [CLR_W-1:0] clr_cnt;

  logic op_q;
  logic [ADDR_W-3:0] a_q;
  logic [ADDR_W-1:0] tgt_q;
  logic [1:0] lvl_q;
  logic [15:0] lfsr;
  logic [ADDR_W-3:0] a_in;

  assign a_in = in_branch[ADDR_W-1:2];
  assign status.clear_done = (clr_cnt == CLR_W'((L1_SETS > L2_SETS ? L1_SETS : L2_SETS) - 1));

  // Skewed set per way: A1 rotated w times, XOR A2
  always_comb begin
    logic [L2_SET_BITS-1:0] a1, a2;
    a1 = a_in[L2_SET_BITS-1:0];
    a2 = L2_SET_BITS'(a_in >> L2_SET_BITS);
    for (int w = 0; w < L2_WAYS; w++) begin
      l2_idx[w] = a1 ^ a2;
      a1 = {a1[L2_SET_BITS-2:0], a1[L2_SET_BITS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= in_opcode;
      a_q <= a_in;
      tgt_q <= in_target;
      lvl_q <= in_level;
      l2_idx_q <= l2_idx;
      l1_rd <= l1_row_t'(l1_mem[a_in[L1_SET_BITS-1:0]]);
    end
    if (l1_we) l1_mem[l1_waddr] <= L1_ROW_W'(l1_wdata);
  end

  for (genvar g = 0; g < L2_WAYS; g++) begin : g_l2
    logic [L2_ROW_W-1:0] mem [L2_SETS];
    always_ff @(posedge clk) begin
      if (cmd.capture) l2_rd[g] <= mem[l2_idx[g]];
      if (l2_we[g])
        mem[cmd.clear ? clr_cnt[L2_SET_BITS-1:0] : l2_idx_q[g]] <=
          cmd.clear ? '0 : L2_ROW_W'(l2_wdata);
    end
  end

  // Resolve step
  logic h1, h2, f1, f2, fnd1, fnd2;
  logic [L1_WB-1:0] w1, v1;
  logic [L2_WB-1:0] w2, v2;
  logic [L1_TAG_W-1:0] t1tag;
  logic [L2_TAG_BITS-1:0] t2tag;
  logic [AGE_W-1:0] old_age;
  logic [15:0] lfsr_nx;
  logic [31:0] rnd;
  l2_ent_t e2 [L2_WAYS];
  logic [87:0] out_data_next;

  always_comb begin
    t1tag = L1_TAG_W'(a_q >> L1_SET_BITS);
    t2tag = a_q[L2_TAG_BITS-1:0];
    f1 = cmd.resolve && op_q == OP_FILL && (lvl_q == LVL_L1 || lvl_q == LVL_BOTH);
    f2 = cmd.resolve && op_q == OP_FILL && (lvl_q == LVL_L2 || lvl_q == LVL_BOTH);
    h1 = 1'b0; w1 = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--)
      if (l1_rd.v[w] && l1_rd.tag[w] == t1tag) begin
        h1 = 1'b1; w1 = L1_WB'(w);
      end
    h2 = 1'b0; w2 = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      e2[w] = l2_ent_t'(l2_rd[w]);
      if (e2[w].v && e2[w].tag == t2tag) begin
        h2 = 1'b1; w2 = L2_WB'(w);
      end
    end
    // L1 victim: hit, first invalid, else first oldest
    fnd1 = 1'b0; v1 = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--)
      if (!l1_rd.v[w]) begin
        fnd1 = 1'b1; v1 = L1_WB'(w);
      end
    if (!fnd1) begin
      v1 = '0;
      for (int w = 1; w < L1_WAYS; w++)
        if (l1_rd.age[w] > l1_rd.age[v1]) v1 = L1_WB'(w);
    end
    if (h1) v1 = w1;
    old_age = h1 ? l1_rd.age[w1] : AGE_W'(L1_WAYS - 1);
    l1_wdata = l1_rd;
    for (int w = 0; w < L1_WAYS; w++)
      if (L1_WB'(w) != v1 && l1_rd.age[w] < old_age)
        l1_wdata.age[w] = l1_rd.age[w] + AGE_W'(1);
    l1_wdata.age[v1] = '0;
    l1_wdata.v[v1] = 1'b1;
    l1_wdata.tag[v1] = t1tag;
    l1_wdata.tgt[v1] = tgt_q;
    // L2 victim: hit, first invalid, else random
    lfsr_nx = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
    rnd = 32'(lfsr_nx) * 32'(L2_WAYS);
    fnd2 = 1'b0; v2 = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--)
      if (!e2[w].v) begin
        fnd2 = 1'b1; v2 = L2_WB'(w);
      end
    if (!fnd2) v2 = L2_WB'(rnd >> 16);
    if (h2) v2 = w2;
    l2_wdata.v = 1'b1;
    l2_wdata.tag = t2tag;
    l2_wdata.tgt = tgt_q[L2_TARGET_BITS-1:0];
    // Write enables and clear pass
    if (cmd.clear) begin
      l1_we = 1'b1;
      l1_waddr = clr_cnt[L1_SET_BITS-1:0];
      l1_wdata = '0;
      l2_we = '1;
    end else begin
      l1_we = f1;
      l1_waddr = a_q[L1_SET_BITS-1:0];
      l2_we = '0;
      if (f2) l2_we[v2] = 1'b1;
    end
  end

  // Result word packed as on the output bus
  always_comb begin
    out_data_next = '0;
    out_data_next[0] = h1;
    out_data_next[48:1] = h1 ? l1_rd.tgt[w1] : '0;
    out_data_next[50:49] = WAY_OUT_W'(f1 ? v1 : w1);
    out_data_next[51] = h2;
    out_data_next[83:52] = h2 ? L2_TGT_OUT_W'(e2[w2].tgt) : '0;
    out_data_next[85:84] = WAY_OUT_W'(f2 ? v2 : w2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      lfsr <= LFSR_SEED;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + CLR_W'(1);
      if (f2 && !h2 && !fnd2) lfsr <= lfsr_nx;
      if (cmd.resolve) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (cmd.resolve) out_data <= out_data_next;
  end
endmodule
`default_nettype wire

// ===== sv/skewed_two_level_btb.sv =====
// Top level of the two-level skewed branch target buffer
`timescale 1ns / 1ps
`default_nettype none
// Two-level branch target buffer: each input word is a lookup or a fill of one branch.
// L1 is set-associative with true LRU; L2 is skewed-associative with one memory per way.
// An item is read first (the L1 row and every L2 way's skewed set), then resolved: compare,
// pick a victim, write back and load the result register; no new item is accepted until
// the resolve step is done. After reset a clearing pass over max(2^L1_SET_BITS,
// 2^L2_SET_BITS) rows (1024 by default) runs before s_tready rises.
module skewed_two_level_btb #(
  parameter int L1_SET_BITS = 6,
  parameter int L1_WAYS = 4,
  parameter int L2_SET_BITS = 10,
  parameter int L2_WAYS = 4,
  parameter int L2_TAG_BITS = 12,
  parameter int L2_TARGET_BITS = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // tdata: opcode[0], branch_address[48:1], branch_target[96:49], level[98:97]
  input  wire  [103:0] s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // tdata: l1_hit[0], l1_target[48:1], l1_way[50:49], l2_hit[51],
  //        l2_partial_target[83:52], l2_way[85:84]
  output logic [87:0]  m_tdata
);
  import stlb_pkg::*;
  stlb_cmd_t cmd;
  stlb_status_t status;
  logic [87:0] od;

  stlb_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .out_busy(m_tvalid && !m_tready), .status, .cmd
  );

  stlb_dp #(
    .L1_SET_BITS(L1_SET_BITS), .L1_WAYS(L1_WAYS), .L2_SET_BITS(L2_SET_BITS),
    .L2_WAYS(L2_WAYS), .L2_TAG_BITS(L2_TAG_BITS), .L2_TARGET_BITS(L2_TARGET_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .status,
    .in_opcode(s_tdata[0]), .in_branch(s_tdata[48:1]), .in_target(s_tdata[96:49]),
    .in_level(s_tdata[98:97]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
  );
  assign m_tdata = od;
endmodule
`default_nettype wire

// ===== sv/stlb_checker.sv =====
// Port-level checker for the branch target buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "skewed_two_level_btb_macros.svh"
module stlb_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [87:0] m_tdata
);
  `BTB_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output dropped")
  `BTB_ASSERT(a_result, s_tvalid && s_tready |=> ##1 m_tvalid, "no result after accept")
  `BTB_ASSERT(a_gap, s_tvalid && s_tready |=> !s_tready, "accepted in back-to-back cycles")
  `BTB_ASSERT(a_miss1, m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == 48'd0, "L1 miss target")
  `BTB_ASSERT_RST(a_rst, rst |=> !s_tready && !m_tvalid, "ready during reset")
endmodule
bind skewed_two_level_btb stlb_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/skewed_two_level_btb_test.sv =====
// Self-checking testbench for the two-level skewed branch target buffer
`timescale 1ns / 1ps
`default_nettype none
module skewed_two_level_btb_test;
  import stlb_pkg::*;

  localparam int L1_SET_BITS = 6;
  localparam int L1_WAYS = 4;
  localparam int L2_SET_BITS = 10;
  localparam int L2_WAYS = 4;
  localparam int L2_TAG_BITS = 12;
  localparam int L1_SETS = 1 << L1_SET_BITS;
  localparam int L2_SETS = 1 << L2_SET_BITS;
  localparam int RANDOM_WORDS = 1300;
  localparam logic [1:0] LVL_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]        level;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] branch;
    logic              opcode;
  } btb_req_t;

  typedef struct packed {
    logic [1:0]              l2_way;
    logic [L2_TGT_OUT_W-1:0] l2_target;
    logic                    l2_hit;
    logic [1:0]              l1_way;
    logic [ADDR_W-1:0]       l1_target;
    logic                    l1_hit;
  } btb_resp_t;

  // Directed row: request plus an optional typed-in expected response
  typedef struct {
    btb_req_t  req;
    bit        has_resp;
    btb_resp_t resp;
  } stim_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [103:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [87:0] m_tdata;

  skewed_two_level_btb u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow copy of both table levels
  bit              l1_vld[L1_SETS][L1_WAYS];
  logic [39:0]     l1_tag[L1_SETS][L1_WAYS];
  logic [47:0]     l1_tgt[L1_SETS][L1_WAYS];
  int unsigned     l1_age[L1_SETS][L1_WAYS];
  bit              l2_vld[L2_SETS][L2_WAYS];
  logic [11:0]     l2_tag[L2_SETS][L2_WAYS];
  logic [31:0]     l2_tgt[L2_SETS][L2_WAYS];
  logic [15:0]     lfsr;

  btb_resp_t pending_resp[$];
  int        fail_count;
  bit        stim_done;
  bit        hold_sink;   // long receiver hold-off request
  stim_row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  // Compute the response of one request and update the shadow tables
  function automatic btb_resp_t btb_predict(btb_req_t r);
    logic [45:0] a;
    int unsigned s1, v, old;
    int unsigned sets[L2_WAYS];
    logic [9:0] a1, a2;
    logic [39:0] t1;
    logic [11:0] t2;
    bit h1, h2, found;
    int unsigned w1, w2;
    btb_resp_t o;
    a = r.branch[47:2];
    s1 = 32'(a[L1_SET_BITS-1:0]);
    t1 = 40'(a >> L1_SET_BITS);
    t2 = a[L2_TAG_BITS-1:0];
    a1 = a[L2_SET_BITS-1:0];
    a2 = a[2*L2_SET_BITS-1:L2_SET_BITS];
    for (int w = 0; w < L2_WAYS; w++) begin
      sets[w] = 32'(a1 ^ a2);
      a1 = {a1[L2_SET_BITS-2:0], a1[L2_SET_BITS-1]};
    end
    h1 = 0; w1 = 0; h2 = 0; w2 = 0;
    for (int w = 0; w < L1_WAYS; w++)
      if (!h1 && l1_vld[s1][w] && l1_tag[s1][w] == t1) begin
        h1 = 1; w1 = w;
      end
    for (int w = 0; w < L2_WAYS; w++)
      if (!h2 && l2_vld[sets[w]][w] && l2_tag[sets[w]][w] == t2) begin
        h2 = 1; w2 = w;
      end
    o = '0;
    o.l1_hit = h1;
    o.l1_target = h1 ? l1_tgt[s1][w1] : '0;
    o.l1_way = 2'(w1);
    o.l2_hit = h2;
    o.l2_target = h2 ? l2_tgt[sets[w2]][w2] : '0;
    o.l2_way = 2'(w2);
    if (r.opcode == OP_FILL && (r.level == LVL_L1 || r.level == LVL_BOTH)) begin
      v = w1;
      if (!h1) begin
        found = 0;
        for (int w = 0; w < L1_WAYS; w++)
          if (!found && !l1_vld[s1][w]) begin
            found = 1; v = w;
          end
        if (!found) begin
          v = 0;
          for (int w = 1; w < L1_WAYS; w++)
            if (l1_age[s1][w] > l1_age[s1][v]) v = w;
        end
      end
      // LRU: age everyone younger than the touched way
      old = h1 ? l1_age[s1][v] : L1_WAYS - 1;
      for (int w = 0; w < L1_WAYS; w++)
        if (w != v && l1_age[s1][w] < old) l1_age[s1][w]++;
      l1_age[s1][v] = 0;
      l1_vld[s1][v] = 1;
      l1_tag[s1][v] = t1;
      l1_tgt[s1][v] = r.target;
      o.l1_way = 2'(v);
    end
    if (r.opcode == OP_FILL && (r.level == LVL_L2 || r.level == LVL_BOTH)) begin
      v = w2;
      if (!h2) begin
        found = 0;
        for (int w = 0; w < L2_WAYS; w++)
          if (!found && !l2_vld[sets[w]][w]) begin
            found = 1; v = w;
          end
        if (!found) begin
          lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
          v = (32'(lfsr) * L2_WAYS) >> 16;
        end
      end
      l2_vld[sets[v]][v] = 1;
      l2_tag[sets[v]][v] = t2;
      l2_tgt[sets[v]][v] = r.target[31:0];
      o.l2_way = 2'(v);
    end
    return o;
  endfunction

  function automatic btb_req_t mk_req(logic op, logic [47:0] br, logic [47:0] tg,
                                      logic [1:0] lv);
    btb_req_t r;
    r.opcode = op; r.branch = br; r.target = tg; r.level = lv;
    return r;
  endfunction

  function automatic btb_resp_t mk_resp(logic h1, logic [47:0] t1, logic [1:0] w1,
                                        logic h2, logic [31:0] t2, logic [1:0] w2);
    btb_resp_t o;
    o.l1_hit = h1; o.l1_target = t1; o.l1_way = w1;
    o.l2_hit = h2; o.l2_target = t2; o.l2_way = w2;
    return o;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Drive one word and wait for its handshake; queue the expected response.
  // Valid stays high after the handshake and drops at the start of the next idle gap.
  task automatic send_word(btb_req_t r, bit has_resp, btb_resp_t resp);
    btb_resp_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = btb_predict(r);
    if (has_resp && p !== resp) begin
      $display("%0t typed-in row disagrees with prediction: exp %h got %h",
               $time, resp, p);
      fail_count++;
    end
    pending_resp.push_back(has_resp ? resp : p);
  endtask

  // Random request, mostly addresses from a small pool so hits and evictions happen
  function automatic btb_req_t rand_req(ref logic [47:0] pool[16]);
    btb_req_t r;
    int k;
    logic [47:0] rb;
    k = $urandom_range(0, 13);
    rb = rand48();
    r.opcode = 1'($urandom_range(0, 1));
    r.level = 2'($urandom_range(0, 3));
    r.target = rand48();
    if (k < 5) r.branch = pool[$urandom_range(0, 15)];
    else if (k < 8) r.branch = {pool[$urandom_range(0, 15)][47:8], 8'($urandom)};
    else r.branch = rb;
    // Same L1 set, different tags: forces LRU eviction
    if (k == 9) r.branch = {rb[47:8], 8'h40};
    // Few skewed sets and tags: fills every L2 way, then random victims
    if (k >= 10) r.branch = {rb[47:22], 6'd0, rb[15:12], 8'd0, rb[3:0]};
    return r;
  endfunction

  initial begin
    logic [47:0] pool[16];
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    fail_count = 0;
    stim_done = 0;
    hold_sink = 0;
    for (int s = 0; s < L1_SETS; s++)
      for (int w = 0; w < L1_WAYS; w++) begin
        l1_vld[s][w] = 0; l1_age[s][w] = 0; l1_tag[s][w] = '0; l1_tgt[s][w] = '0;
      end
    for (int s = 0; s < L2_SETS; s++)
      for (int w = 0; w < L2_WAYS; w++) begin
        l2_vld[s][w] = 0; l2_tag[s][w] = '0; l2_tgt[s][w] = '0;
      end
    lfsr = LFSR_SEED;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty lookups, extreme fields, each level, refills, eviction
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, LVL_L1), 1, mk_resp(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_req(OP_LOOKUP, '1, '1, LVL_NONE), 1, mk_resp(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_req(OP_FILL, '1, '1, LVL_BOTH), 1, mk_resp(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_req(OP_LOOKUP, '1, '0, LVL_L1), 1,
                     mk_resp(1, '1, 0, 1, '1, 0)});
    rows.push_back('{mk_req(OP_FILL, '0, 48'h5555_5555_5555, LVL_L1), 1,
                     mk_resp(0, 0, 0, 0, 0, 0)});
    rows.push_back('{mk_req(OP_FILL, '0, 48'hAAAA_AAAA_AAAA, LVL_L2), 1,
                     mk_resp(1, 48'h5555_5555_5555, 0, 0, 0, 1)});
    rows.push_back('{mk_req(OP_LOOKUP, '0, '1, LVL_BOTH), 1,
                     mk_resp(1, 48'h5555_5555_5555, 0, 1, 32'hAAAA_AAAA, 1)});
    // Fill with the unused level code writes nothing
    rows.push_back('{mk_req(OP_FILL, 48'h1234_5678_9ABC, '1, LVL_NONE), 0, '0});
    rows.push_back('{mk_req(OP_LOOKUP, 48'h1234_5678_9ABC, '0, LVL_L1), 0, '0});
    // Five tags into one L1 set: fills the set then evicts the oldest way
    for (int i = 1; i <= 5; i++)
      rows.push_back('{mk_req(OP_FILL, {40'(i), 8'h40}, 48'(i * 3), LVL_BOTH), 0, '0});
    rows.push_back('{mk_req(OP_FILL, {40'd3, 8'h40}, 48'h77, LVL_L1), 0, '0});
    rows.push_back('{mk_req(OP_FILL, {40'd6, 8'h40}, 48'h88, LVL_L1), 0, '0});
    // Same skewed sets and tag under many upper bits: rewrite one L2 entry in place
    for (int i = 0; i < 6; i++)
      rows.push_back('{mk_req(OP_FILL, {8'(i), 40'h0}, 48'(i), LVL_L2), 0, '0});
    rows.push_back('{mk_req(OP_LOOKUP, 48'h0300_0000_0000, '0, LVL_L1), 0, '0});
    foreach (rows[i]) send_word(rows[i].req, rows[i].has_resp, rows[i].resp);

    for (int i = 0; i < 16; i++) pool[i] = rand48();
    n = 0;
    while (n < RANDOM_WORDS) begin
      // Pause until everything drains, once mid-run
      if (n == RANDOM_WORDS / 2) begin
        s_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_WORDS / 4) hold_sink = 1;
      if (n % 200 == 199) pool[$urandom_range(0, 15)] = rand48();
      send_word(rand_req(pool), 0, '0);
      n++;
    end
    s_tvalid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stalls, plus one long hold-off
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    btb_resp_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[85:0];
      if (pending_resp.size() == 0) begin
        $display("%0t unexpected response: exp none got %h", $time, got);
        fail_count++;
      end else begin
        exp = pending_resp.pop_front();
        if (got.l1_hit !== exp.l1_hit) begin
          $display("%0t l1_hit: exp %h got %h", $time, exp.l1_hit, got.l1_hit);
          fail_count++;
        end
        if (got.l1_target !== exp.l1_target) begin
          $display("%0t l1_target: exp %h got %h", $time, exp.l1_target, got.l1_target);
          fail_count++;
        end
        if (got.l1_way !== exp.l1_way) begin
          $display("%0t l1_way: exp %h got %h", $time, exp.l1_way, got.l1_way);
          fail_count++;
        end
        if (got.l2_hit !== exp.l2_hit) begin
          $display("%0t l2_hit: exp %h got %h", $time, exp.l2_hit, got.l2_hit);
          fail_count++;
        end
        if (got.l2_target !== exp.l2_target) begin
          $display("%0t l2_partial_target: exp %h got %h", $time, exp.l2_target,
                   got.l2_target);
          fail_count++;
        end
        if (got.l2_way !== exp.l2_way) begin
          $display("%0t l2_way: exp %h got %h", $time, exp.l2_way, got.l2_way);
          fail_count++;
        end
      end
    end
  end

  // End of run: drain, settle, report
  initial begin
    wait (stim_done);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_resp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
